### sv/sbm_pkg.sv
// Shared types and constants of the session bandwidth monitor.
`timescale 1ns / 1ps
`default_nettype none

package sbm_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned NumSessions = 16;
  localparam int unsigned IdxW = (NumSessions > 1) ? $clog2(NumSessions) : 1;
  localparam int unsigned CntW = ($clog2(NumSessions + 1) > 5) ? $clog2(NumSessions + 1) : 5;

  // Quotient bits produced by the divider, one per cycle.
  localparam int unsigned DivBits = 64;
  localparam int unsigned DivCntW = $clog2(DivBits);

  typedef enum logic [1:0] {
    OpRecord = 2'd0,
    OpRate   = 2'd1,
    OpReset  = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] session_key;
    logic [31:0] byte_count;
    logic [63:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic        status;
    logic [63:0] rate_in;
    logic [63:0] total_in;
    logic [4:0]  session_count;
  } out_req_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic win_reset;
    logic clear_all;
    logic scan_start;
    logic scan_step;
    logic alloc;
    logic set_full;
    logic mem_read;
    logic update;
    logic mul;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  op;
    logic scan_end;
    logic hit;
    logic full;
    logic dt_zero;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/sbm_ctrl.sv
// Controller state machine of the session bandwidth monitor.
`timescale 1ns / 1ps
`default_nettype none

module sbm_ctrl import sbm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t sts_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    StIdle     = 8'b0000_0001,
    StDispatch = 8'b0000_0010,
    StSearch   = 8'b0000_0100,
    StRead     = 8'b0000_1000,
    StUpdate   = 8'b0001_0000,
    StMul      = 8'b0010_0000,
    StDiv      = 8'b0100_0000,
    StFinish   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StDispatch;
        end
      end
      StDispatch: begin
        unique case (sts_i.op)
          OpReset: begin
            cmd_o.win_reset = 1'b1;
            state_d         = StFinish;
          end
          OpClear: begin
            cmd_o.clear_all = 1'b1;
            state_d         = StFinish;
          end
          default: begin
            cmd_o.scan_start = 1'b1;
            state_d          = StSearch;
          end
        endcase
      end
      StSearch: begin
        // The end of the used slots is checked first: entries past it hold stale keys.
        if (sts_i.scan_end) begin
          if (sts_i.full) begin
            cmd_o.set_full = 1'b1;
            state_d        = StFinish;
          end else begin
            cmd_o.alloc = 1'b1;
            state_d     = StRead;
          end
        end else if (sts_i.hit) begin
          state_d = StRead;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StRead: begin
        cmd_o.mem_read = 1'b1;
        state_d        = (sts_i.op == OpRecord) ? StUpdate : StMul;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StFinish;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.dt_zero ? StFinish : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sv/sbm_dpath.sv
// Datapath of the session bandwidth monitor: key table, window counters and divider.
`timescale 1ns / 1ps
`default_nettype none

module sbm_dpath import sbm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_req_t   in_req_i,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     sts_o,
  output out_req_t       out_req_o
);

  // Table and running totals.
  logic [15:0]      key_mem [NumSessions];
  logic [63:0]      win_mem [NumSessions];
  logic [NumSessions-1:0] win_valid_q;
  logic [CntW-1:0]  used_q;
  logic [63:0]      window_start_q;
  logic [63:0]      running_total_q;

  // Latched request and working registers.
  in_req_t          req_q;
  logic [CntW-1:0]  scan_q;
  logic             full_q;
  logic [63:0]      rd_data_q;
  logic             rd_valid_q;
  logic [63:0]      divisor_q;
  logic [63:0]      rem_q;
  logic [63:0]      quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  out_req_t         out_q;

  logic [IdxW-1:0]  slot;
  logic [63:0]      win_val;
  logic [63:0]      product;
  logic [63:0]      dt;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_diff;
  logic             ge;

  assign slot    = scan_q[IdxW-1:0];
  // A window counter cleared by a window reset reads as zero until it is written again.
  assign win_val = rd_valid_q ? rd_data_q : 64'd0;
  // Multiply by 1000 as 1024 - 16 - 8.
  assign product = (win_val << 10) - (win_val << 4) - (win_val << 3);
  assign dt      = req_q.now_ms - window_start_q;

  assign rem_sh   = {rem_q, quo_q[63]};
  assign rem_diff = rem_sh - {1'b0, divisor_q};
  assign ge       = !rem_diff[64];

  assign sts_o.op       = req_q.operation;
  assign sts_o.scan_end = (scan_q == used_q);
  assign sts_o.hit      = (key_mem[slot] == req_q.session_key);
  assign sts_o.full     = (used_q >= CntW'(NumSessions));
  assign sts_o.dt_zero  = (dt == 64'd0);
  assign sts_o.div_last = (div_cnt_q == DivCntW'(DivBits - 1));

  assign out_req_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q     <= '0;
      used_q          <= '0;
      window_start_q  <= '0;
      running_total_q <= '0;
    end else begin
      if (cmd_i.win_reset) begin
        win_valid_q    <= '0;
        window_start_q <= req_q.now_ms;
      end
      if (cmd_i.clear_all) begin
        win_valid_q     <= '0;
        used_q          <= '0;
        window_start_q  <= req_q.now_ms;
        running_total_q <= '0;
      end
      if (cmd_i.alloc) begin
        win_valid_q[slot] <= 1'b0;
        used_q            <= used_q + CntW'(1);
      end
      if (cmd_i.update) begin
        win_valid_q[slot] <= 1'b1;
        running_total_q   <= running_total_q + {32'd0, req_q.byte_count};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q  <= in_req_i;
      full_q <= 1'b0;
      quo_q  <= '0;
    end
    if (cmd_i.scan_start) begin
      scan_q <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q + CntW'(1);
    end
    if (cmd_i.alloc) begin
      key_mem[slot] <= req_q.session_key;
    end
    if (cmd_i.set_full) begin
      full_q <= 1'b1;
    end
    if (cmd_i.mem_read) begin
      rd_data_q  <= win_mem[slot];
      rd_valid_q <= win_valid_q[slot];
    end
    if (cmd_i.update) begin
      win_mem[slot] <= win_val + {32'd0, req_q.byte_count};
    end
    if (cmd_i.mul) begin
      quo_q     <= sts_o.dt_zero ? 64'd0 : product;
      divisor_q <= dt;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= ge ? rem_diff[63:0] : rem_sh[63:0];
      quo_q     <= {quo_q[62:0], ge};
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
    if (cmd_i.load_out) begin
      out_q.status        <= full_q;
      out_q.rate_in       <= quo_q;
      out_q.total_in      <= running_total_q;
      out_q.session_count <= used_q[4:0];
    end
  end

endmodule

`default_nettype wire

### sv/session_bandwidth_monitor_unit.sv
// Top level of the session bandwidth monitor: controller plus datapath.
// Each item is accepted and decoded. A window reset or clear ends there; a record or rate
// query searches the keys one slot per cycle. A record reads and updates its slot; a rate
// query reads it, multiplies by 1000 and, unless no time passed, runs the one-bit-per-cycle
// restoring divider. Items run one at a time; results are registered; a new request is taken
// while the previous result waits. Asynchronous active-low reset empties the table and totals.
`timescale 1ns / 1ps
`default_nettype none

module session_bandwidth_monitor_unit import sbm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_req_t      out_req_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  sbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sbm_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_req_o (out_req_o)
  );

endmodule

`default_nettype wire
